// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== rtl/aoor_pkg.sv =====
// Shared types and constants of the analog out-of-range alarm.
package aoor_pkg;

   // Command codes of an input transaction.
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_ACK    = 2'd2;
   localparam logic [1:0] CMD_MAINT  = 2'd3;

   // Alarm states, which double as notification codes.
   localparam logic [1:0] ST_NORMAL = 2'd0;
   localparam logic [1:0] ST_HIGH   = 2'd1;
   localparam logic [1:0] ST_LOW    = 2'd2;
   localparam logic [1:0] ST_FAULT  = 2'd3;

   localparam logic [2:0] EV_ESC    = 3'd4;
   localparam logic [2:0] PEND_NONE = 3'd7;

   localparam logic [31:0] SAME_AS_DELAY = 32'hFFFF_FFFF;

   // Configuration register indexes.
   localparam logic [2:0] CSR_HIGH_LIMIT    = 3'd0;
   localparam logic [2:0] CSR_LOW_LIMIT     = 3'd1;
   localparam logic [2:0] CSR_DEADBAND      = 3'd2;
   localparam logic [2:0] CSR_DELAY         = 3'd3;
   localparam logic [2:0] CSR_NORMAL_DELAY  = 3'd4;
   localparam logic [2:0] CSR_ESCALATE      = 3'd5;

   typedef struct packed {
      logic [31:0] hi_lim;
      logic [31:0] lo_lim;
      logic [30:0] deadband;
      logic [31:0] delay_s;
      logic [31:0] normal_delay_s;
      logic [31:0] esc_after_s;
   } cfg_type;

   // A classified command as it waits in the queue.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] now;
      logic [31:0] value;
      logic        fault;
      logic        mon;
      logic        gt_hi;    // value above high limit
      logic        lt_lo;    // value below low limit
      logic        lt_hidb;  // value below high limit minus deadband
      logic        gt_lodb;  // value above low limit plus deadband
   } cmd_type;

endpackage

// ===== rtl/aoor_front.sv =====
// Front end: accepts input transactions and classifies the sample against the limits.
module aoor_front
   import aoor_pkg::*;
(
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_now,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_sensor_fault,
   input  logic               req_maint_on,
   input  cfg_type            cfg,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_item
);

   logic signed [33:0] val_w;
   logic signed [33:0] hi_w;
   logic signed [33:0] lo_w;
   logic signed [33:0] db_w;
   logic signed [33:0] hi_db;
   logic signed [33:0] lo_db;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Extended to 34 bits so that limit plus or minus deadband never overflows.
   assign val_w = {{2{req_sample_value[31]}}, req_sample_value};
   assign hi_w  = {{2{cfg.hi_lim[31]}}, cfg.hi_lim};
   assign lo_w  = {{2{cfg.lo_lim[31]}}, cfg.lo_lim};
   assign db_w  = {3'b000, cfg.deadband};
   assign hi_db = hi_w - db_w;
   assign lo_db = lo_w + db_w;

   always_comb begin
      q_item.cmd     = req_cmd;
      q_item.now     = req_now;
      q_item.value   = req_sample_value;
      q_item.fault   = req_sensor_fault;
      q_item.mon     = req_maint_on;
      q_item.gt_hi   = val_w > hi_w;
      q_item.lt_lo   = val_w < lo_w;
      q_item.lt_hidb = val_w < hi_db;
      q_item.gt_lodb = val_w > lo_db;
   end

endmodule

// ===== rtl/aoor_queue.sv =====
// Small register queue between the front end and the back end.
module aoor_queue
   import aoor_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_item
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   cmd_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   assign full      = count_ff == FULL_COUNT;
   assign not_empty = count_ff != '0;
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/aoor_back.sv =====
// Back end: alarm state, delay timers, escalation and the notification buffer.
module aoor_back
   import aoor_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_valid,
   input  cmd_type            q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_event_res,
   output logic [31:0]        rsp_event_time,
   output logic signed [31:0] rsp_event_value,
   output logic [1:0]         rsp_point_state,
   output logic               rsp_last_note
);

   typedef struct packed {
      logic [1:0]      st;
      logic [1:0]      nst;
      logic [2:0]      pt;
      logic [31:0]     ps;
      logic [31:0]     asn;
      logic [31:0]     lt;
      logic [31:0]     lv;
      logic            unack;
      logic            escf;
      logic            maint;
      logic            ps_fresh;   // pending start was set to this transaction's time
      logic            asn_fresh;  // alarm start was set to this transaction's time
      logic [2:0][2:0] ev;
      logic [1:0]      n;
   } step_type;

   // Report the current state and arm the escalation timer for an alarm.
   function automatic step_type notify(step_type s, logic [31:0] now);
      step_type r;
      r = s;
      if (r.n != 2'd3) begin
         r.ev[r.n] = {1'b0, r.st};
         r.n       = r.n + 2'd1;
      end
      r.nst = r.st;
      if (r.st == ST_HIGH || r.st == ST_LOW) begin
         r.unack     = 1'b1;
         r.asn       = now;
         r.asn_fresh = 1'b1;
         r.escf      = 1'b0;
      end
      return r;
   endfunction

   function automatic step_type go_to(step_type s, logic [1:0] to, logic [31:0] now);
      step_type r;
      r    = s;
      r.st = to;
      r.pt = PEND_NONE;
      if (!r.maint) begin
         r = notify(r, now);
      end
      return r;
   endfunction

   logic [1:0]      st_ff;
   logic [1:0]      nst_ff;
   logic [2:0]      pt_ff;
   logic [31:0]     ps_ff;
   logic [31:0]     asn_ff;
   logic [31:0]     lt_ff;
   logic [31:0]     lv_ff;
   logic            unack_ff;
   logic            escf_ff;
   logic            maint_ff;

   logic            ob_valid_ff;
   logic            ob_valid_in;
   logic [2:0][2:0] ob_ev_ff;
   logic [1:0]      ob_n_ff;
   logic [1:0]      ob_idx_ff;
   logic [1:0]      ob_idx_in;
   logic [31:0]     ob_time_ff;
   logic [31:0]     ob_value_ff;
   logic [1:0]      ob_state_ff;

   logic            take;
   logic            take_last;
   logic            exec;
   step_type        s;

   assign take      = ob_valid_ff && !rsp_stall;
   assign take_last = take && (ob_idx_ff == ob_n_ff - 2'd1);
   assign exec      = q_valid && (!ob_valid_ff || take_last);
   assign q_pop     = exec;

   assign rsp_valid       = ob_valid_ff;
   assign rsp_event_res   = ob_ev_ff[ob_idx_ff];
   assign rsp_event_time  = ob_time_ff;
   assign rsp_event_value = ob_value_ff;
   assign rsp_point_state = ob_state_ff;
   assign rsp_last_note   = ob_idx_ff == ob_n_ff - 2'd1;

   // One whole command per cycle, held while the output buffer still holds notifications
   // that are not taken; elapsed-time compares run in parallel against the stored start times.
   always_comb begin
      logic [31:0] el_p;
      logic [31:0] el_a;
      logic        p_ge_dly;
      logic        p_ge_nd;
      logic        a_ge_esc;
      logic [2:0]  t;
      logic        use_nd;
      logic        due;
      logic        run_tmr;

      el_p     = q_item.now - ps_ff;
      el_a     = q_item.now - asn_ff;
      p_ge_dly = el_p >= cfg.delay_s;
      p_ge_nd  = el_p >= cfg.normal_delay_s;
      a_ge_esc = el_a >= cfg.esc_after_s;
      t        = PEND_NONE;
      use_nd   = 1'b0;
      due      = 1'b0;
      run_tmr  = 1'b1;

      s.st        = st_ff;
      s.nst       = nst_ff;
      s.pt        = pt_ff;
      s.ps        = ps_ff;
      s.asn       = asn_ff;
      s.lt        = lt_ff;
      s.lv        = lv_ff;
      s.unack     = unack_ff;
      s.escf      = escf_ff;
      s.maint     = maint_ff;
      s.ps_fresh  = 1'b0;
      s.asn_fresh = 1'b0;
      s.ev        = '0;
      s.n         = 2'd0;

      // A transaction whose time runs backward leaves everything untouched.
      if (q_item.now >= lt_ff) begin
         s.lt = q_item.now;

         if (q_item.cmd == CMD_SAMPLE) begin
            s.lv = q_item.value;
            if (q_item.fault) begin
               if (s.st != ST_FAULT) begin
                  s = go_to(s, ST_FAULT, q_item.now);
               end
               s.pt    = PEND_NONE;
               run_tmr = 1'b0;
            end else begin
               if (s.st == ST_FAULT) begin
                  s = go_to(s, ST_NORMAL, q_item.now);
               end
               case (s.st)
                  ST_NORMAL: begin
                     if (q_item.gt_hi) begin
                        t = {1'b0, ST_HIGH};
                     end else if (q_item.lt_lo) begin
                        t = {1'b0, ST_LOW};
                     end
                  end
                  ST_HIGH: begin
                     if (q_item.lt_lo) begin
                        t = {1'b0, ST_LOW};
                     end else if (q_item.lt_hidb) begin
                        t = {1'b0, ST_NORMAL};
                     end
                  end
                  ST_LOW: begin
                     if (q_item.gt_hi) begin
                        t = {1'b0, ST_HIGH};
                     end else if (q_item.gt_lodb) begin
                        t = {1'b0, ST_NORMAL};
                     end
                  end
                  default: begin
                     t = PEND_NONE;
                  end
               endcase
               if (t == PEND_NONE) begin
                  s.pt = PEND_NONE;
               end else if (t != s.pt) begin
                  s.pt       = t;
                  s.ps       = q_item.now;
                  s.ps_fresh = 1'b1;
               end
            end
         end

         if (run_tmr && s.st != ST_FAULT && s.pt != PEND_NONE) begin
            use_nd = (s.pt == {1'b0, ST_NORMAL}) && (cfg.normal_delay_s != SAME_AS_DELAY);
            if (s.ps_fresh) begin
               due = use_nd ? (cfg.normal_delay_s == '0) : (cfg.delay_s == '0);
            end else begin
               due = use_nd ? p_ge_nd : p_ge_dly;
            end
            if (due) begin
               s = go_to(s, s.pt[1:0], q_item.now);
            end
         end

         if (q_item.cmd == CMD_ACK) begin
            s.unack = 1'b0;
         end else if (q_item.cmd == CMD_MAINT) begin
            if (q_item.mon) begin
               s.maint = 1'b1;
            end else if (s.maint) begin
               s.maint = 1'b0;
               if (s.st != s.nst) begin
                  s = notify(s, q_item.now);
               end
            end
         end

         // A freshly started alarm has zero elapsed time and cannot escalate yet.
         if (s.unack && !s.escf && !s.maint && cfg.esc_after_s != '0 &&
             !s.asn_fresh && a_ge_esc) begin
            if (s.n != 2'd3) begin
               s.ev[s.n] = EV_ESC;
               s.n       = s.n + 2'd1;
            end
            s.escf = 1'b1;
         end
      end
   end

   always_comb begin
      ob_valid_in = ob_valid_ff;
      ob_idx_in   = ob_idx_ff;
      if (exec) begin
         ob_valid_in = s.n != 2'd0;
         ob_idx_in   = 2'd0;
      end else if (take_last) begin
         ob_valid_in = 1'b0;
      end else if (take) begin
         ob_idx_in = ob_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         ob_ev_ff    <= s.ev;
         ob_n_ff     <= s.n;
         ob_time_ff  <= q_item.now;
         ob_value_ff <= s.lv;
         ob_state_ff <= s.st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_NORMAL;
         nst_ff      <= ST_NORMAL;
         pt_ff       <= PEND_NONE;
         ps_ff       <= '0;
         asn_ff      <= '0;
         lt_ff       <= '0;
         lv_ff       <= '0;
         unack_ff    <= 1'b0;
         escf_ff     <= 1'b0;
         maint_ff    <= 1'b0;
         ob_valid_ff <= 1'b0;
         ob_idx_ff   <= 2'd0;
      end else begin
         if (exec) begin
            st_ff    <= s.st;
            nst_ff   <= s.nst;
            pt_ff    <= s.pt;
            ps_ff    <= s.ps;
            asn_ff   <= s.asn;
            lt_ff    <= s.lt;
            lv_ff    <= s.lv;
            unack_ff <= s.unack;
            escf_ff  <= s.escf;
            maint_ff <= s.maint;
         end
         ob_valid_ff <= ob_valid_in;
         ob_idx_ff   <= ob_idx_in;
      end
   end

endmodule

// ===== rtl/analog_out_of_range_alarm.sv =====
// Top level of the analog out-of-range alarm: configuration registers and the three stages.
//
// Each input transaction is a timestamped command (sample, tick, acknowledge or
// maintenance on/off) and produces zero to three notification transactions on the
// rsp_ channel, the last of them marked by rsp_last_note. An accepted command
// enters a queue of QUEUE_DEPTH entries; the back end executes one command per
// cycle while its output buffer is free or hands over its last notification, and
// delivers the notifications from that buffer one per cycle while rsp_stall is low.
// The command is registered in the queue and its notifications in the output
// buffer before rsp_valid rises. The input side keeps accepting while results
// wait, until the queue is full. Configuration is written through csr_we,
// csr_index and csr_wdata and must only change while no command is in flight.
// QUEUE_DEPTH must be 2 or more.
module analog_out_of_range_alarm
   import aoor_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_now,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_sensor_fault,
   input  logic               req_maint_on,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_event_res,
   output logic [31:0]        rsp_event_time,
   output logic signed [31:0] rsp_event_value,
   output logic [1:0]         rsp_point_state,
   output logic               rsp_last_note
);

   cfg_type cfg_ff;
   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_valid;
   cmd_type push_item;
   cmd_type pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hi_lim         <= 32'h7FFF_FFFF;
         cfg_ff.lo_lim         <= 32'h8000_0000;
         cfg_ff.deadband       <= '0;
         cfg_ff.delay_s        <= '0;
         cfg_ff.normal_delay_s <= SAME_AS_DELAY;
         cfg_ff.esc_after_s    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HIGH_LIMIT:   cfg_ff.hi_lim         <= csr_wdata;
            CSR_LOW_LIMIT:    cfg_ff.lo_lim         <= csr_wdata;
            CSR_DEADBAND:     cfg_ff.deadband       <= csr_wdata[30:0];
            CSR_DELAY:        cfg_ff.delay_s        <= csr_wdata;
            CSR_NORMAL_DELAY: cfg_ff.normal_delay_s <= csr_wdata;
            CSR_ESCALATE:     cfg_ff.esc_after_s    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   aoor_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_now          (req_now),
      .req_sample_value (req_sample_value),
      .req_sensor_fault (req_sensor_fault),
      .req_maint_on     (req_maint_on),
      .cfg              (cfg_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   aoor_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (pop_item)
   );

   aoor_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_event_time  (rsp_event_time),
      .rsp_event_value (rsp_event_value),
      .rsp_point_state (rsp_point_state),
      .rsp_last_note   (rsp_last_note)
   );

endmodule

// ===== rtl/aoor_checker.sv =====
// Port-level checks on the notification channel, bound to the top level.
`include "assert_macros.svh"

module aoor_checker
   import aoor_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [31:0] rsp_event_time,
   input logic [1:0]  rsp_point_state,
   input logic        rsp_last_note
);

   // Escalation is decided after every state notification, so it always closes a group.
   `ASSERT_IMPLY(a_esc_is_last, clock, reset, rsp_valid && rsp_event_res == EV_ESC, rsp_last_note)

   // Notifications of one command follow each other without a gap.
   `ASSERT_NEXT(a_group_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_last_note, rsp_valid)

   // All notifications of one command share its time and final state.
   `ASSERT_NEXT(a_group_consistent, clock, reset, rsp_valid && !rsp_stall && !rsp_last_note, rsp_event_time == $past(rsp_event_time) && rsp_point_state == $past(rsp_point_state))

   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_res) && $stable(rsp_event_time))

endmodule

bind analog_out_of_range_alarm aoor_checker u_aoor_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_res   (rsp_event_res),
   .rsp_event_time  (rsp_event_time),
   .rsp_point_state (rsp_point_state),
   .rsp_last_note   (rsp_last_note)
);

// ===== tb/sv/alarm_event_checker.sv =====
// Checker for the out-of-range alarm: mirrors the registers, predicts and compares notifications.
module alarm_event_checker
   import aoor_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_now,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_sensor_fault,
   input  logic               req_maint_on,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_event_res,
   input  logic [31:0]        rsp_event_time,
   input  logic signed [31:0] rsp_event_value,
   input  logic [1:0]         rsp_point_state,
   input  logic               rsp_last_note,
   output int                 fail_count,
   output int                 outstanding,
   output int                 compared
);

   typedef struct packed {
      logic [2:0]  res;
      logic [31:0] at;
      logic [31:0] value;
      logic [1:0]  state;
      logic        last;
   } note_type;

   note_type expected_notes[$];
   note_type step_notes[$];

   // Register mirror.
   logic signed [31:0] high_lim, low_lim;
   logic [30:0]        dead_band;
   logic [31:0]        hold_s, return_hold_s, escalate_s;

   // Alarm state as the block should hold it.
   logic [1:0]         alarm_st, told_st;
   logic [2:0]         target;
   logic               unacked, escalated, in_maint;
   logic [31:0]        target_since, alarm_t0, last_t, step_t;
   logic signed [31:0] last_val;

   function automatic void post(input logic [2:0] res);
      note_type n;
      if (step_notes.size() < 3) begin
         n.res   = res;
         n.at    = step_t;
         n.value = last_val;
         n.state = '0;
         n.last  = 1'b0;
         step_notes.push_back(n);
      end
   endfunction

   function automatic void announce();
      post({1'b0, alarm_st});
      told_st = alarm_st;
      if (alarm_st == ST_HIGH || alarm_st == ST_LOW) begin
         unacked   = 1'b1;
         alarm_t0  = step_t;
         escalated = 1'b0;
      end
   endfunction

   function automatic void enter_state(input logic [1:0] to);
      alarm_st = to;
      target   = PEND_NONE;
      if (!in_maint)
         announce();
   endfunction

   // Limit compares run in 64 bits so that the deadband offsets cannot overflow.
   function automatic logic [2:0] wanted(input logic signed [31:0] v);
      longint x, hi, lo, db;
      x  = v;
      hi = high_lim;
      lo = low_lim;
      db = longint'(dead_band);
      wanted = PEND_NONE;
      case (alarm_st)
         ST_NORMAL: begin
            if (x > hi) wanted = {1'b0, ST_HIGH};
            else if (x < lo) wanted = {1'b0, ST_LOW};
         end
         ST_HIGH: begin
            if (x < lo) wanted = {1'b0, ST_LOW};
            else if (x < hi - db) wanted = {1'b0, ST_NORMAL};
         end
         ST_LOW: begin
            if (x > hi) wanted = {1'b0, ST_HIGH};
            else if (x > lo + db) wanted = {1'b0, ST_NORMAL};
         end
         default: ;
      endcase
   endfunction

   function automatic void run_hold();
      logic [31:0] need, gone;
      if (alarm_st == ST_FAULT || target == PEND_NONE)
         return;
      need = hold_s;
      if (target == {1'b0, ST_NORMAL} && return_hold_s != SAME_AS_DELAY)
         need = return_hold_s;
      gone = step_t - target_since;
      if (gone >= need)
         enter_state(target[1:0]);
   endfunction

   function automatic void predict_command(input logic [1:0] cmd, input logic [31:0] now,
                                           input logic signed [31:0] val,
                                           input logic flt, input logic mon);
      logic [2:0]  t;
      logic [31:0] gone;
      note_type    n;
      step_notes.delete();
      step_t = now;
      // A timestamp older than the last accepted one is dropped without a trace.
      if (now < last_t)
         return;
      last_t = now;
      case (cmd)
         CMD_SAMPLE: begin
            last_val = val;
            if (flt) begin
               if (alarm_st != ST_FAULT)
                  enter_state(ST_FAULT);
               target = PEND_NONE;
            end else begin
               if (alarm_st == ST_FAULT)
                  enter_state(ST_NORMAL);
               t = wanted(val);
               if (t == PEND_NONE) begin
                  target = PEND_NONE;
               end else if (t != target) begin
                  target       = t;
                  target_since = now;
               end
               run_hold();
            end
         end
         CMD_TICK: run_hold();
         CMD_ACK: begin
            run_hold();
            unacked = 1'b0;
         end
         default: begin
            run_hold();
            if (mon) begin
               in_maint = 1'b1;
            end else if (in_maint) begin
               in_maint = 1'b0;
               if (alarm_st != told_st)
                  announce();
            end
         end
      endcase
      gone = now - alarm_t0;
      if (unacked && !escalated && !in_maint && escalate_s != 0 && gone >= escalate_s) begin
         post(EV_ESC);
         escalated = 1'b1;
      end
      for (int k = 0; k < step_notes.size(); k++) begin
         n       = step_notes[k];
         n.state = alarm_st;
         n.last  = (k == step_notes.size() - 1);
         expected_notes.push_back(n);
      end
   endfunction

   function automatic void compare_field(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      end
   endfunction

   // Signals are sampled at the falling edge, where they hold the values of the next rising edge.
   always @(negedge clock) begin
      note_type e;
      if (reset) begin
         high_lim      = 32'h7FFF_FFFF;
         low_lim       = 32'h8000_0000;
         dead_band     = '0;
         hold_s        = '0;
         return_hold_s = SAME_AS_DELAY;
         escalate_s    = '0;
         alarm_st      = ST_NORMAL;
         told_st       = ST_NORMAL;
         target        = PEND_NONE;
         unacked       = 1'b0;
         escalated     = 1'b0;
         in_maint      = 1'b0;
         target_since  = '0;
         alarm_t0      = '0;
         last_t        = '0;
         last_val      = '0;
         expected_notes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HIGH_LIMIT:   high_lim      = csr_wdata;
               CSR_LOW_LIMIT:    low_lim       = csr_wdata;
               CSR_DEADBAND:     dead_band     = csr_wdata[30:0];
               CSR_DELAY:        hold_s        = csr_wdata;
               CSR_NORMAL_DELAY: return_hold_s = csr_wdata;
               CSR_ESCALATE:     escalate_s    = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_command(req_cmd, req_now, req_sample_value, req_sensor_fault, req_maint_on);
         if (rsp_valid && !rsp_stall) begin
            if (expected_notes.size() == 0) begin
               fail_count++;
               $display("%0t: notification res %0d time %0h with nothing expected",
                        $time, rsp_event_res, rsp_event_time);
            end else begin
               e = expected_notes.pop_front();
               compared++;
               compare_field("event_res", 32'(e.res), 32'(rsp_event_res));
               compare_field("event_time", e.at, rsp_event_time);
               compare_field("event_value", e.value, rsp_event_value);
               compare_field("point_state", 32'(e.state), 32'(rsp_point_state));
               compare_field("last_note", 32'(e.last), 32'(rsp_last_note));
            end
         end
      end
      outstanding = expected_notes.size();
   end

endmodule

// ===== tb/sv/tb_analog_out_of_range_alarm.sv =====
// Testbench top for the out-of-range alarm: clock, reset, stimulus and the verdict.
module tb_analog_out_of_range_alarm;
   import aoor_pkg::*;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_we           = 1'b0;
   logic [2:0]         csr_index        = CSR_HIGH_LIMIT;
   logic [31:0]        csr_wdata        = '0;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd          = CMD_TICK;
   logic [31:0]        req_now          = '0;
   logic signed [31:0] req_sample_value = '0;
   logic               req_sensor_fault = 1'b0;
   logic               req_maint_on     = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [2:0]         rsp_event_res;
   logic [31:0]        rsp_event_time;
   logic signed [31:0] rsp_event_value;
   logic [1:0]         rsp_point_state;
   logic               rsp_last_note;

   int fail_count, outstanding, compared;
   int commands_sent = 0;
   int stale_sent = 0;
   int settings_used = 0;

   // Latest forward timestamp sent, and the limits in force, for steering the samples.
   logic [31:0]        t_now = '0;
   logic signed [31:0] hi_set = 32'h7FFF_FFFF;
   logic signed [31:0] lo_set = 32'h8000_0000;
   logic [30:0]        db_set = '0;
   bit                 req_calm = 1'b0;
   bit                 rsp_calm = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   analog_out_of_range_alarm dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_now          (req_now),
      .req_sample_value (req_sample_value),
      .req_sensor_fault (req_sensor_fault),
      .req_maint_on     (req_maint_on),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_event_time   (rsp_event_time),
      .rsp_event_value  (rsp_event_value),
      .rsp_point_state  (rsp_point_state),
      .rsp_last_note    (rsp_last_note)
   );

   alarm_event_checker event_check (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_now          (req_now),
      .req_sample_value (req_sample_value),
      .req_sensor_fault (req_sensor_fault),
      .req_maint_on     (req_maint_on),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_event_time   (rsp_event_time),
      .rsp_event_value  (rsp_event_value),
      .rsp_point_state  (rsp_point_state),
      .rsp_last_note    (rsp_last_note),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .compared         (compared)
   );

   // Now and then a side switches between random gaps and back-to-back transactions.
   function automatic int draw_gap(ref bit calm);
      if ($urandom_range(0, 15) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic send(input logic [1:0] cmd, input logic [31:0] now,
                       input logic [31:0] val, input logic flt, input logic mon);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_now          <= now;
      req_sample_value <= val;
      req_sensor_fault <= flt;
      req_maint_on     <= mon;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      if (now < t_now) begin
         stale_sent++;
      end else begin
         t_now = now;
         commands_sent++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // A command may cause no notification, so give the block time to finish it before a write.
   task automatic settle();
      drain();
      repeat (16) @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] hi, input logic [31:0] lo,
                                input logic [31:0] db, input logic [31:0] hold,
                                input logic [31:0] ret_hold, input logic [31:0] esc);
      logic [2:0]  idx [6];
      logic [31:0] val [6];
      idx = '{CSR_HIGH_LIMIT, CSR_LOW_LIMIT, CSR_DEADBAND, CSR_DELAY, CSR_NORMAL_DELAY,
              CSR_ESCALATE};
      val = '{hi, lo, db, hold, ret_hold, esc};
      hi_set = hi;
      lo_set = lo;
      db_set = db[30:0];
      for (int i = 0; i < 6; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Samples sit near limits, deadband edges, range ends or midpoint, or are fully random.
   function automatic logic [31:0] pick_value();
      longint base, off;
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2, 3: base = longint'(hi_set);
         4: base = longint'(lo_set);
         5: base = longint'(hi_set) - longint'(db_set);
         6: base = longint'(lo_set) + longint'(db_set);
         7: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: base = (longint'(hi_set) + longint'(lo_set)) / 2;
      endcase
      off = longint'($urandom_range(0, 6)) - 3;
      if ($urandom_range(0, 3) == 0)
         off = off * 65536;
      return 32'(base + off);
   endfunction

   task automatic random_command();
      int          r, dt;
      logic [32:0] s;
      logic [31:0] now;
      logic [1:0]  cmd;
      logic        flt;
      r = $urandom_range(0, 99);
      if (r < 5 && t_now != 0) begin
         now = $urandom_range(0, t_now - 1);
      end else begin
         dt = (r < 80) ? $urandom_range(0, 4) :
              (r < 95) ? $urandom_range(5, 30) : $urandom_range(0, 65535);
         s = {1'b0, t_now} + dt;
         now = s[32] ? 32'hFFFF_FFFF : s[31:0];
      end
      r = $urandom_range(0, 99);
      cmd = (r < 55) ? CMD_SAMPLE : (r < 75) ? CMD_TICK : (r < 85) ? CMD_ACK : CMD_MAINT;
      flt = (cmd == CMD_SAMPLE) ? ($urandom_range(0, 9) == 0) : 1'($urandom_range(0, 1));
      send(cmd, now, pick_value(), flt, 1'($urandom_range(0, 1)));
   endtask

   task automatic run_items(input int n);
      int goal;
      goal = commands_sent + n;
      while (commands_sent < goal) begin
         random_command();
         if ($urandom_range(0, 24) == 0)
            drain();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Limits of +10.0 and -10.0 with a deadband of 1.0, no delay, escalation after 5 s.
      load_settings(32'h000A_0000, 32'hFFF6_0000, 32'h0001_0000, 0, SAME_AS_DELAY, 5);
      send(CMD_SAMPLE, 1, 32'h0000_0000, 1'b0, 1'b0);
      send(CMD_SAMPLE, 2, 32'h7FFF_FFFF, 1'b0, 1'b1);
      send(CMD_TICK, 3, 32'h1234_5678, 1'b1, 1'b0);
      send(CMD_TICK, 8, 32'h0, 1'b0, 1'b0);
      send(CMD_SAMPLE, 9, 32'h8000_0000, 1'b0, 1'b0);
      send(CMD_ACK, 10, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send(CMD_SAMPLE, 11, 32'h0009_8000, 1'b0, 1'b0);
      send(CMD_SAMPLE, 12, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send(CMD_SAMPLE, 12, 32'h5A5A_A5A5, 1'b1, 1'b0);
      send(CMD_SAMPLE, 13, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send(CMD_SAMPLE, 5, 32'h0, 1'b0, 1'b0);
      send(CMD_MAINT, 14, 32'h0, 1'b0, 1'b1);
      send(CMD_MAINT, 14, 32'h0, 1'b0, 1'b1);
      send(CMD_SAMPLE, 15, 32'hFFFF_0000, 1'b0, 1'b0);
      send(CMD_MAINT, 16, 32'h0, 1'b0, 1'b0);
      send(CMD_MAINT, 16, 32'h0, 1'b0, 1'b0);
      send(CMD_SAMPLE, 17, 32'h000A_0000, 1'b0, 1'b0);
      send(CMD_SAMPLE, 18, 32'h000A_0001, 1'b0, 1'b0);
      send(CMD_SAMPLE, 19, 32'h0003_0000, 1'b1, 1'b0);
      send(CMD_SAMPLE, 30, 32'h0000_0000, 1'b0, 1'b0);
      send(CMD_SAMPLE, 31, 32'hFFF6_0000, 1'b0, 1'b0);
      send(CMD_SAMPLE, 32, 32'hFFF5_FFFF, 1'b0, 1'b0);
      send(CMD_SAMPLE, 33, 32'hFFF7_0000, 1'b0, 1'b0);
      send(CMD_ACK, 34, 32'h0, 1'b0, 1'b0);

      settle();
      load_settings(32'h0005_0000, 32'hFFFB_0000, 32'h0000_8000, 3, SAME_AS_DELAY, 8);
      run_items(18);

      settle();
      load_settings($urandom, $urandom, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
      run_items(18);

      settle();
      load_settings(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 5, 1);
      run_items(18);

      settle();
      load_settings(0, 0, $urandom_range(0, 32'h0003_0000), $urandom_range(0, 6),
                    $urandom_range(0, 10), $urandom_range(0, 15));
      run_items(18);

      // The last setting runs at late timestamps up to the top of the time range.
      settle();
      load_settings(32'h0002_0000, 32'hFFFD_0000, 32'h0000_4000, 2, 7, 4);
      t_now = 32'h8000_0000 + $urandom_range(0, 4096);
      run_items(9);
      t_now = 32'hFFFF_FF80;
      run_items(9);
      send(CMD_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send(CMD_TICK, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);

      settle();
      $display("Covered %0d commands and %0d stale timestamps over %0d register settings.",
               commands_sent, stale_sent, settings_used);
      $display("%0d notifications were compared field by field.", compared);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result side: a random stall before each notification transaction.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         @(posedge clock);
      end
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
